### design/djb2_pkg.sv
`timescale 1ns / 1ps
// Package for the djb2 distinct-key counter.
// Holds fixed widths, hash constants and the sequencer state type.
// No dependencies.
package djb2_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned COUNT_W = 10;

  localparam logic [HASH_W-1:0]  HASH_START = 32'd5381;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_WRITE,
    S_RESULT
  } state_e;

endpackage

### design/djb2_hash_set_distinct_counter.sv
`timescale 1ns / 1ps
// djb2 distinct-key counter: hashes and packs a key, then looks it up in a
// bucketed set held in block memory and inserts it when new.
// Depends on djb2_pkg.
//
//  channel | signals                                    | dir | beat
//  --------+--------------------------------------------+-----+----------------------
//  in      | in_valid_i in_ready_o ch_i last_i          | in  | one key character
//  out     | out_valid_o out_ready_i is_new_o           | out | one result per key
//          | bucket_full_o distinct_count_o key_hash_o  |     |
//
// A character without last is taken in the idle state. A character with last
// starts a probe of the key's bucket, a memory read then a compare per way,
// then an insert when a free way is found, then a load of the result.
// After reset the valid store is cleared, one entry a cycle, over all
// BUCKETS*WAYS entries; in_ready_o stays low during that pass.
// A waiting result holds the sequencer in its result state until taken.
module djb2_hash_set_distinct_counter #(
  parameter int unsigned BUCKETS   = 128,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned KEY_CHARS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [djb2_pkg::CHAR_W-1:0]  ch_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_new_o,
  output logic                         bucket_full_o,
  output logic [djb2_pkg::COUNT_W-1:0] distinct_count_o,
  output logic [djb2_pkg::HASH_W-1:0]  key_hash_o
);

  localparam int unsigned DEPTH  = BUCKETS * WAYS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned KEY_W  = djb2_pkg::CHAR_W * KEY_CHARS;

  djb2_pkg::state_e state_q, state_d;

  logic [djb2_pkg::HASH_W-1:0]  hash_q, hash_d;
  logic [KEY_W-1:0]             key_q, key_d;
  logic [djb2_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [WAY_W-1:0]             way_q, way_d;
  logic [ADDR_W-1:0]            clr_q, clr_d;
  logic [djb2_pkg::COUNT_W-1:0] stored_q, stored_d;

  logic                         out_valid_q, out_valid_d;
  logic                         is_new_q, is_new_d;
  logic                         full_q, full_d;
  logic                         load_out;
  logic                         ins_q, ins_d;
  logic                         bfull_q, bfull_d;
  logic [djb2_pkg::COUNT_W-1:0] out_cnt_q;
  logic [djb2_pkg::HASH_W-1:0]  out_hash_q;

  logic [KEY_W-1:0]  key_mem [DEPTH];
  logic              vld_mem [DEPTH];
  logic [KEY_W-1:0]  rd_key_q;
  logic              rd_vld_q;

  logic [BKT_W-1:0]  bucket;
  logic [ADDR_W-1:0] look_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              vld_we;
  logic              vld_wdata;
  logic              key_we;
  logic              take;
  logic              accept;
  logic              hit;

  assign bucket    = BKT_W'(hash_q & djb2_pkg::HASH_W'(BUCKETS - 1));
  assign look_addr = ADDR_W'(ADDR_W'(bucket) * ADDR_W'(WAYS)) + ADDR_W'(way_q);
  assign wr_addr   = (state_q == djb2_pkg::S_CLEAR) ? clr_q : look_addr;
  assign hit       = rd_vld_q && (rd_key_q == key_q);

  assign in_ready_o = (state_q == djb2_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign take       = accept && (ch_i != '0) && (cnt_q < djb2_pkg::CNT_W'(KEY_CHARS));

  // memories
  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wdata;
    end
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    rd_vld_q <= vld_mem[look_addr];
    rd_key_q <= key_mem[look_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= djb2_pkg::S_CLEAR;
      hash_q      <= djb2_pkg::HASH_START;
      key_q       <= '0;
      cnt_q       <= '0;
      way_q       <= '0;
      clr_q       <= '0;
      stored_q    <= '0;
      out_valid_q <= 1'b0;
      ins_q       <= 1'b0;
      bfull_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      key_q       <= key_d;
      cnt_q       <= cnt_d;
      way_q       <= way_d;
      clr_q       <= clr_d;
      stored_q    <= stored_d;
      out_valid_q <= out_valid_d;
      ins_q       <= ins_d;
      bfull_q     <= bfull_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      is_new_q   <= is_new_d;
      full_q     <= full_d;
      out_cnt_q  <= stored_q;
      out_hash_q <= hash_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    way_d       = way_q;
    clr_d       = clr_q;
    stored_d    = stored_q;
    ins_d       = ins_q;
    bfull_d     = bfull_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_new_d    = ins_q;
    full_d      = bfull_q;
    load_out    = 1'b0;
    vld_we      = 1'b0;
    vld_wdata   = 1'b0;
    key_we      = 1'b0;

    unique case (state_q)
      djb2_pkg::S_CLEAR: begin
        vld_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = djb2_pkg::S_IDLE;
        end
      end
      djb2_pkg::S_IDLE: begin
        if (take) begin
          hash_d = (hash_q << 5) + hash_q + djb2_pkg::HASH_W'(ch_i);
          for (int unsigned i = 0; i < KEY_CHARS; i++) begin
            if (cnt_q == djb2_pkg::CNT_W'(i)) begin
              key_d[djb2_pkg::CHAR_W*i +: djb2_pkg::CHAR_W] = ch_i;
            end
          end
          cnt_d = cnt_q + 1'b1;
        end
        if (accept && last_i) begin
          way_d   = '0;
          ins_d   = 1'b0;
          bfull_d = 1'b0;
          state_d = djb2_pkg::S_READ;
        end
      end
      djb2_pkg::S_READ: begin
        state_d = djb2_pkg::S_CMP;
      end
      djb2_pkg::S_CMP: begin
        // ways fill from the bottom and never empty: first free way ends the probe
        if (hit) begin
          state_d = djb2_pkg::S_RESULT;
        end else if (!rd_vld_q) begin
          state_d = djb2_pkg::S_WRITE;
        end else if (way_q == WAY_W'(WAYS - 1)) begin
          bfull_d = 1'b1;
          state_d = djb2_pkg::S_RESULT;
        end else begin
          way_d   = way_q + 1'b1;
          state_d = djb2_pkg::S_READ;
        end
      end
      djb2_pkg::S_WRITE: begin
        vld_we    = 1'b1;
        vld_wdata = 1'b1;
        key_we    = 1'b1;
        ins_d     = 1'b1;
        if (stored_q != djb2_pkg::COUNT_MAX) begin
          stored_d = stored_q + 1'b1;
        end
        state_d = djb2_pkg::S_RESULT;
      end
      djb2_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          hash_d      = djb2_pkg::HASH_START;
          key_d       = '0;
          cnt_d       = '0;
          state_d     = djb2_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = djb2_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign is_new_o         = is_new_q;
  assign bucket_full_o    = full_q;
  assign distinct_count_o = out_cnt_q;
  assign key_hash_o       = out_hash_q;

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (stored_q >= $past(stored_q)))
    else $error("distinct count decreased");

  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && bucket_full_o))
    else $error("result both new and bucket full");

  a_write_after_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == djb2_pkg::S_WRITE) |->
      ($past(state_q) == djb2_pkg::S_CMP) && !$past(rd_vld_q))
    else $error("insert without a free way found");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == djb2_pkg::S_CLEAR) |-> !in_ready_o && !key_we)
    else $error("activity during clear pass");

endmodule
